// ===== rtl/lexicographic_permutation_stepper_macros.svh =====
// Assertion macros used by the checker file of the permutation stepper.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LEXICOGRAPHIC_PERMUTATION_STEPPER_MACROS_SVH
`define LEXICOGRAPHIC_PERMUTATION_STEPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    localparam int MAX_ELEMS = 8;
    localparam int ELEM_W    = 4;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int SIZE_W    = 4;
    localparam int SIGN_W    = 2;
    localparam int PERM_W    = 32;
    localparam int PACK_N    = (MAX_ELEMS < 8) ? MAX_ELEMS : 8;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int ADV_BIT   = 0;
    localparam int SIGN_LSB  = 1;
    localparam int PERM_LSB  = SIGN_LSB + SIGN_W;

    localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

    typedef struct packed {
        logic              clear;
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [ELEM_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr_a;
        logic [IDX_W-1:0]  raddr_b;
    } store_req_t;

    typedef struct packed {
        logic start;
        logic restart;
        logic unstart;
    } cmd_t;

    typedef struct packed {
        logic              advanced;
        logic [SIGN_W-1:0] sign;
        logic [PERM_W-1:0] perm_packed;
    } result_t;

    // Value an entry holds in the unstarted state: the first is zero, the others
    // their one-based position.
    function automatic logic [ELEM_W-1:0] reset_elem(input logic [IDX_W-1:0] addr);
        logic [ELEM_W-1:0] val;
        if (addr == '0)
        begin
            val = '0;
        end
        else
        begin
            val = ELEM_W'(addr) + ELEM_W'(1);
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lps_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8
) (
    input  wire                                       clk,
    input  wire                                       we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                          wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                          rdata_a,
    output logic [WIDTH-1:0]                          rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ===== rtl/lps_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lps_store
    import lps_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  store_req_t        req,
    output logic [ELEM_W-1:0] rdata_a,
    output logic [ELEM_W-1:0] rdata_b
);

    logic [MAX_ELEMS-1:0] valid_reg;
    logic [MAX_ELEMS-1:0] valid_next;
    logic                 vld_a_reg;
    logic                 vld_b_reg;
    logic [IDX_W-1:0]     addr_a_reg;
    logic [IDX_W-1:0]     addr_b_reg;
    logic [ELEM_W-1:0]    ram_a;
    logic [ELEM_W-1:0]    ram_b;

    lps_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ELEMS)
    ) u_ram (
        .clk     (clk),
        .we      (req.we),
        .waddr   (req.waddr),
        .wdata   (req.wdata),
        .raddr_a (req.raddr_a),
        .raddr_b (req.raddr_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // A clear drops every entry back to its unstarted value; a write in the same
    // cycle still lands.
    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vld_a_reg  <= valid_reg[req.raddr_a];
        vld_b_reg  <= valid_reg[req.raddr_b];
        addr_a_reg <= req.raddr_a;
        addr_b_reg <= req.raddr_b;
    end

    assign rdata_a = vld_a_reg ? ram_a : reset_elem(addr_a_reg);
    assign rdata_b = vld_b_reg ? ram_b : reset_elem(addr_b_reg);

endmodule

`default_nettype wire

// ===== rtl/lps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lps_ctrl
    import lps_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  cmd_t              cmd,
    input  wire  [CNT_W-1:0]  n_act,
    input  wire               res_ready,
    input  wire  [ELEM_W-1:0] rdata_a,
    input  wire  [ELEM_W-1:0] rdata_b,
    output store_req_t        store_req,
    output logic              idle,
    output logic              done,
    output result_t           result
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PIV_RD  = 4'd1;
    localparam logic [3:0] ST_PIV_CMP = 4'd2;
    localparam logic [3:0] ST_SUC_RD  = 4'd3;
    localparam logic [3:0] ST_SUC_CMP = 4'd4;
    localparam logic [3:0] ST_SWP_A   = 4'd5;
    localparam logic [3:0] ST_SWP_B   = 4'd6;
    localparam logic [3:0] ST_REV_RD  = 4'd7;
    localparam logic [3:0] ST_REV_WA  = 4'd8;
    localparam logic [3:0] ST_REV_WB  = 4'd9;
    localparam logic [3:0] ST_PACK    = 4'd10;
    localparam logic [3:0] ST_PK_END  = 4'd11;
    localparam logic [3:0] ST_DONE    = 4'd12;

    logic [3:0]        state_reg,   state_next;
    logic [SIGN_W-1:0] parity_reg,  parity_next;
    logic              cap_en_reg,  cap_en_next;
    logic [IDX_W-1:0]  piv_reg,     piv_next;
    logic [IDX_W-1:0]  succ_reg,    succ_next;
    logic [IDX_W-1:0]  lo_reg,      lo_next;
    logic [IDX_W-1:0]  hi_reg,      hi_next;
    logic [IDX_W-1:0]  k_reg,       k_next;
    logic [IDX_W-1:0]  cap_idx_reg, cap_idx_next;
    logic [ELEM_W-1:0] pivval_reg,  pivval_next;
    logic [ELEM_W-1:0] succval_reg, succval_next;
    logic              adv_reg,     adv_next;
    logic [PERM_W-1:0] perm_reg,    perm_next;

    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  pk_last;
    logic [SIGN_W-1:0] parity_neg;
    logic              started;

    assign last_idx   = IDX_W'(n_act - CNT_W'(1));
    assign pk_last    = (n_act > CNT_W'(PACK_N)) ? IDX_W'(PACK_N - 1) : last_idx;
    assign parity_neg = (~parity_reg) + SIGN_W'(1);
    assign started    = !cmd.restart && (parity_reg != SIGN_ZERO);

    always_comb
    begin
        state_next   = state_reg;
        parity_next  = parity_reg;
        cap_en_next  = 1'b0;
        piv_next     = piv_reg;
        succ_next    = succ_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        cap_idx_next = cap_idx_reg;
        pivval_next  = pivval_reg;
        succval_next = succval_reg;
        adv_next     = adv_reg;
        perm_next    = perm_reg;
        store_req    = '0;
        done         = 1'b0;

        // Packing captures the read data in the cycle after the read it issued.
        if (cap_en_reg)
        begin
            for (int i = 0; i < PACK_N; i++)
            begin
                if (cap_idx_reg == IDX_W'(i))
                begin
                    perm_next[i*ELEM_W +: ELEM_W] = rdata_a;
                end
            end
        end

        if (cmd.unstart)
        begin
            store_req.clear = 1'b1;
            parity_next     = SIGN_ZERO;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    perm_next = '0;
                    k_next    = '0;
                    if (cmd.restart)
                    begin
                        store_req.clear = 1'b1;
                        parity_next     = SIGN_ZERO;
                    end
                    if (!started)
                    begin
                        store_req.we    = 1'b1;
                        store_req.waddr = '0;
                        store_req.wdata = ELEM_W'(1);
                        parity_next     = SIGN_POS;
                        adv_next        = 1'b1;
                        state_next      = ST_PACK;
                    end
                    else if (n_act == CNT_W'(1))
                    begin
                        adv_next   = 1'b0;
                        state_next = ST_PACK;
                    end
                    else
                    begin
                        piv_next   = IDX_W'(n_act - CNT_W'(2));
                        state_next = ST_PIV_RD;
                    end
                end
            end
            ST_PIV_RD:
            begin
                store_req.raddr_a = piv_reg;
                store_req.raddr_b = piv_reg + IDX_W'(1);
                state_next        = ST_PIV_CMP;
            end
            ST_PIV_CMP:
            begin
                if (rdata_a > rdata_b)
                begin
                    if (piv_reg == '0)
                    begin
                        adv_next   = 1'b0;
                        state_next = ST_PACK;
                    end
                    else
                    begin
                        piv_next   = piv_reg - IDX_W'(1);
                        state_next = ST_PIV_RD;
                    end
                end
                else
                begin
                    pivval_next  = rdata_a;
                    succval_next = rdata_b;
                    succ_next    = piv_reg + IDX_W'(1);
                    if ((piv_reg + IDX_W'(1)) == last_idx)
                    begin
                        state_next = ST_SWP_A;
                    end
                    else
                    begin
                        state_next = ST_SUC_RD;
                    end
                end
            end
            ST_SUC_RD:
            begin
                store_req.raddr_a = succ_reg + IDX_W'(1);
                state_next        = ST_SUC_CMP;
            end
            ST_SUC_CMP:
            begin
                if (rdata_a > pivval_reg)
                begin
                    succ_next    = succ_reg + IDX_W'(1);
                    succval_next = rdata_a;
                    if ((succ_reg + IDX_W'(1)) == last_idx)
                    begin
                        state_next = ST_SWP_A;
                    end
                    else
                    begin
                        state_next = ST_SUC_RD;
                    end
                end
                else
                begin
                    state_next = ST_SWP_A;
                end
            end
            ST_SWP_A:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = piv_reg;
                store_req.wdata = succval_reg;
                parity_next     = parity_neg;
                state_next      = ST_SWP_B;
            end
            ST_SWP_B:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = succ_reg;
                store_req.wdata = pivval_reg;
                lo_next         = piv_reg + IDX_W'(1);
                hi_next         = last_idx;
                if ((piv_reg + IDX_W'(1)) < last_idx)
                begin
                    state_next = ST_REV_RD;
                end
                else
                begin
                    adv_next   = 1'b1;
                    state_next = ST_PACK;
                end
            end
            ST_REV_RD:
            begin
                store_req.raddr_a = lo_reg;
                store_req.raddr_b = hi_reg;
                state_next        = ST_REV_WA;
            end
            ST_REV_WA:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = lo_reg;
                store_req.wdata = rdata_b;
                succval_next    = rdata_a;
                state_next      = ST_REV_WB;
            end
            ST_REV_WB:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = hi_reg;
                store_req.wdata = succval_reg;
                parity_next     = parity_neg;
                lo_next         = lo_reg + IDX_W'(1);
                hi_next         = hi_reg - IDX_W'(1);
                if ((lo_reg + IDX_W'(1)) < (hi_reg - IDX_W'(1)))
                begin
                    state_next = ST_REV_RD;
                end
                else
                begin
                    adv_next   = 1'b1;
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                store_req.raddr_a = k_reg;
                cap_en_next       = 1'b1;
                cap_idx_next      = k_reg;
                if (k_reg == pk_last)
                begin
                    state_next = ST_PK_END;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_PK_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            parity_reg <= SIGN_ZERO;
            cap_en_reg <= 1'b0;
            perm_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            parity_reg <= parity_next;
            cap_en_reg <= cap_en_next;
            perm_reg   <= perm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_reg     <= piv_next;
        succ_reg    <= succ_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        k_reg       <= k_next;
        cap_idx_reg <= cap_idx_next;
        pivval_reg  <= pivval_next;
        succval_reg <= succval_next;
        adv_reg     <= adv_next;
    end

    assign idle                 = (state_reg == ST_IDLE);
    assign result.advanced      = adv_reg;
    assign result.sign          = parity_reg;
    assign result.perm_packed   = perm_reg;

endmodule

`default_nettype wire

// ===== rtl/lexicographic_permutation_stepper.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_tvalid/s_tready  | s_tdata[0] restart
// m_        | out       | m_tvalid/m_tready  | m_tdata advanced, sign, perm_packed
// cfg_      | in        | cfg_valid/cfg_ready| cfg_data perm_size
//
// A turn for n elements steps down to the pivot and along its successors, each
// step a read and then a compare; it swaps pivot and successor with two writes,
// as the store has one write port, reverses the tail with a read and two writes
// per swapped pair, and then packs the elements with one read each.
// Reset is asynchronous and active low; it leaves the stepper unstarted at full size.
// A stalled result transaction holds in the output register while the next turn runs.
`timescale 1ns / 1ps
`default_nettype none

module lexicographic_permutation_stepper
    import lps_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [S_TDATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] advanced, [2:1] sign, [34:3] perm_packed
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [SIZE_W-1:0]    cfg_data   // perm_size
);

    logic [SIZE_W-1:0] perm_size_reg;
    logic [CNT_W-1:0]  n_act;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    result_t           out_reg;
    result_t           result;
    cmd_t              cmd;
    store_req_t        store_req;
    logic [ELEM_W-1:0] rdata_a;
    logic [ELEM_W-1:0] rdata_b;
    logic              idle;
    logic              done;
    logic              res_ready;

    // The size register is always writable; a write also sends the stepper back
    // to its unstarted state, as a restart would.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_size_reg <= SIZE_W'(MAX_ELEMS);
        end
        else if (cfg_valid)
        begin
            perm_size_reg <= cfg_data;
        end
    end

    // A size of zero counts as one, and anything above the built size is clamped.
    always_comb
    begin
        if (perm_size_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (perm_size_reg > SIZE_W'(MAX_ELEMS))
        begin
            n_act = CNT_W'(MAX_ELEMS);
        end
        else
        begin
            n_act = CNT_W'(perm_size_reg);
        end
    end

    // Input transactions are taken whenever the sequencer is idle, even with an
    // earlier result still waiting in the output register.
    assign s_tready    = idle;
    assign cmd.start   = s_tvalid && idle;
    assign cmd.restart = s_tdata[0];
    assign cmd.unstart = cfg_valid;

    // The sequencer only hands over a result once the output slot is free.
    assign res_ready = !m_tvalid_reg || m_tready;

    lps_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    lps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .n_act     (n_act),
        .res_ready (res_ready),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .store_req (store_req),
        .idle      (idle),
        .done      (done),
        .result    (result)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (done)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.perm_packed, out_reg.sign, out_reg.advanced});

endmodule

`default_nettype wire

// ===== rtl/lps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lexicographic_permutation_stepper_macros.svh"

module lps_checker
    import lps_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire [S_TDATA_W-1:0] s_tdata,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [M_TDATA_W-1:0] m_tdata
);

    logic              in_take;
    logic              out_stall;
    logic [SIGN_W-1:0] out_sign;
    logic              sign_ok;
    logic              first_ok;

    assign in_take   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign out_sign  = m_tdata[SIGN_LSB +: SIGN_W];
    assign sign_ok   = (out_sign == SIGN_POS) || (out_sign == SIGN_NEG);
    assign first_ok  = (m_tdata[PERM_LSB +: ELEM_W] != '0);

    // A result that is not taken stays offered unchanged.
    `LPS_ASSERT_NXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Every result comes from a started stepper, so its sign is never zero.
    `LPS_ASSERT_IMP(a_sign_valid, m_tvalid, sign_ok, "result sign is not plus or minus one")

    // The first element of a started permutation is never the unstarted mark.
    `LPS_ASSERT_IMP(a_first_elem, m_tvalid, first_ok, "first element of result is zero")

    // Taking a transaction starts a turn, so the input side closes right after it.
    `LPS_ASSERT_NXT(a_busy_after_accept, in_take, !s_tready, "input ready again at once")

endmodule

bind lexicographic_permutation_stepper lps_checker u_lps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
